[design/uvsig_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package uvsig_pkg;

  // default upper bound on latitude and longitude line counts
  localparam int DEF_MAX_LINES = 256;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_LAT_LINES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_LINES = 2'd1;

  localparam logic [CFG_W-1:0] LAT_LINES_RST  = 9'd10;
  localparam logic [CFG_W-1:0] LONG_LINES_RST = 9'd10;

  // smallest usable line count
  localparam int MIN_LINES = 3;

  // vertex index width
  localparam int IDX_W = 16;

  // walk regions
  typedef logic [1:0] region_t;
  localparam region_t REGION_TOP = 2'd0;
  localparam region_t REGION_MID = 2'd1;
  localparam region_t REGION_BOT = 2'd2;

endpackage

`default_nettype wire

[design/uv_sphere_index_generator.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  in_restart
// out_      output     out_valid/out_stall  out_index_a/b/c, out_last_triangle
// cfg_      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one triangle per clock while out_stall is low; an item passes the
// input register, then the result register; walk counters step once per item
// rst_n is synchronous: clears the walk, both valid flags and loads the
// line-count registers with 10
// a stalled result holds in the result register while one more item is taken
// into the input register; in_stall rises only when both are full and out_stall
// is high

module uv_sphere_index_generator
  import uvsig_pkg::*;
#(
  parameter int MAX_LINES = DEF_MAX_LINES
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_restart,

  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [IDX_W-1:0]          out_index_a,
  output logic [IDX_W-1:0]          out_index_b,
  output logic [IDX_W-1:0]          out_index_c,
  output logic                      out_last_triangle,

  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  // column and band counter width, effective line count width
  localparam int CW = $clog2(MAX_LINES);
  localparam int LW = $clog2(MAX_LINES + 1);
  // common width for clamping the raw register against the bound
  localparam int XW = (LW > CFG_W) ? LW : CFG_W;

  // configuration registers
  logic [CFG_W-1:0] lat_lines_r;
  logic [CFG_W-1:0] long_lines_r;

  // input register
  logic             s1_valid_r;
  logic             s1_restart_r;

  // walk state
  region_t          region_r,    region_nxt;
  logic [CW-1:0]    band_row_r,  band_row_nxt;
  logic [CW-1:0]    column_r,    column_nxt;
  logic             quad_half_r, quad_half_nxt;
  logic [IDX_W-1:0] row_base_r,  row_base_nxt;

  // result register
  logic             out_valid_r;
  logic [IDX_W-1:0] index_a_r, index_a_nxt;
  logic [IDX_W-1:0] index_b_r, index_b_nxt;
  logic [IDX_W-1:0] index_c_r, index_c_nxt;
  logic             last_r,    last_nxt;

  logic             adv;

  // effective line counts
  logic [XW-1:0]    lat_x, long_x;
  logic [LW-1:0]    lat_eff, long_eff;

  // current walk position, after restart
  region_t          cur_region;
  logic [CW-1:0]    cur_band;
  logic [CW-1:0]    cur_col;
  logic             cur_half;
  logic [IDX_W-1:0] cur_base;
  logic             walk_clear;

  logic             col_open;
  logic [IDX_W-1:0] jp1, jp2, l16, base_l, pole;
  logic [2*LW-1:0]  pole_prod;
  logic [LW:0]      band_inc, lat_less3;

  assign cfg_ready = 1'b1;

  // config writes, unknown indices dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_lines_r  <= LAT_LINES_RST;
      long_lines_r <= LONG_LINES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LAT_LINES:  lat_lines_r  <= cfg_data;
        CFG_LONG_LINES: long_lines_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp to [3, MAX_LINES]
  always_comb begin
    lat_x  = XW'(lat_lines_r);
    long_x = XW'(long_lines_r);
    if (lat_x < XW'(MIN_LINES)) begin
      lat_x = XW'(MIN_LINES);
    end else if (lat_x > XW'(MAX_LINES)) begin
      lat_x = XW'(MAX_LINES);
    end
    if (long_x < XW'(MIN_LINES)) begin
      long_x = XW'(MIN_LINES);
    end else if (long_x > XW'(MAX_LINES)) begin
      long_x = XW'(MAX_LINES);
    end
    lat_eff  = lat_x[LW-1:0];
    long_eff = long_x[LW-1:0];
  end

  // the input register drains whenever the result register is free or taken
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_restart_r <= in_restart;
    end
  end

  // restart or an unused region code starts the walk over at the top cap
  assign walk_clear = s1_restart_r || (region_r != REGION_TOP && region_r != REGION_MID &&
                                       region_r != REGION_BOT);
  assign cur_region = walk_clear ? REGION_TOP : region_r;
  assign cur_band   = walk_clear ? '0 : band_row_r;
  assign cur_col    = walk_clear ? '0 : column_r;
  assign cur_half   = walk_clear ? 1'b0 : quad_half_r;
  assign cur_base   = walk_clear ? '0 : row_base_r;

  // column before the closing or wrap position
  assign col_open  = (LW'(cur_col) < (long_eff - LW'(1)));

  assign jp1       = IDX_W'(cur_col) + IDX_W'(1);
  assign jp2       = jp1 + IDX_W'(1);
  assign l16       = IDX_W'(long_eff);
  assign base_l    = cur_base + l16;
  assign pole_prod = (LW'(lat_eff - LW'(2))) * long_eff;
  assign pole      = IDX_W'(pole_prod) + IDX_W'(1);
  assign band_inc  = (LW + 1)'(cur_band) + (LW + 1)'(1);
  assign lat_less3 = (LW + 1)'(lat_eff) - (LW + 1)'(MIN_LINES);

  always_comb begin
    region_nxt    = cur_region;
    band_row_nxt  = cur_band;
    column_nxt    = cur_col;
    quad_half_nxt = cur_half;
    row_base_nxt  = cur_base;
    index_a_nxt   = '0;
    index_b_nxt   = '0;
    index_c_nxt   = '0;
    last_nxt      = 1'b0;
    case (cur_region)
      REGION_TOP: begin
        if (col_open) begin
          index_b_nxt = jp1;
          index_c_nxt = jp2;
          column_nxt  = CW'(jp1);
        end else begin
          // closing fan triangle wraps back to vertex 1
          index_b_nxt   = l16;
          index_c_nxt   = IDX_W'(1);
          column_nxt    = '0;
          band_row_nxt  = '0;
          row_base_nxt  = '0;
          quad_half_nxt = 1'b0;
          region_nxt    = (lat_eff > LW'(MIN_LINES)) ? REGION_MID : REGION_BOT;
        end
      end
      REGION_MID: begin
        if (col_open) begin
          if (!cur_half) begin
            index_a_nxt = cur_base + jp1;
            index_b_nxt = cur_base + jp2;
            index_c_nxt = base_l + jp1;
          end else begin
            index_a_nxt = base_l + jp1;
            index_b_nxt = cur_base + jp2;
            index_c_nxt = base_l + jp2;
          end
        end else begin
          // wrap quad joins the last column to the first
          if (!cur_half) begin
            index_a_nxt = base_l;
            index_b_nxt = cur_base + IDX_W'(1);
            index_c_nxt = base_l + l16;
          end else begin
            index_a_nxt = base_l + l16;
            index_b_nxt = cur_base + IDX_W'(1);
            index_c_nxt = base_l + IDX_W'(1);
          end
        end
        if (!cur_half) begin
          quad_half_nxt = 1'b1;
        end else begin
          quad_half_nxt = 1'b0;
          if (col_open) begin
            column_nxt = CW'(jp1);
          end else begin
            column_nxt   = '0;
            band_row_nxt = CW'(band_inc);
            row_base_nxt = base_l;
            if (band_inc >= lat_less3) begin
              region_nxt   = REGION_BOT;
              band_row_nxt = '0;
              row_base_nxt = '0;
            end
          end
        end
      end
      default: begin
        // bottom cap fans around the last vertex
        index_a_nxt = pole;
        if (col_open) begin
          index_b_nxt = pole - jp1;
          index_c_nxt = pole - jp2;
          column_nxt  = CW'(jp1);
        end else begin
          index_b_nxt   = pole - l16;
          index_c_nxt   = pole - IDX_W'(1);
          last_nxt      = 1'b1;
          region_nxt    = REGION_TOP;
          band_row_nxt  = '0;
          column_nxt    = '0;
          quad_half_nxt = 1'b0;
          row_base_nxt  = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r    <= REGION_TOP;
      band_row_r  <= '0;
      column_r    <= '0;
      quad_half_r <= 1'b0;
      row_base_r  <= '0;
    end else if (adv) begin
      region_r    <= region_nxt;
      band_row_r  <= band_row_nxt;
      column_r    <= column_nxt;
      quad_half_r <= quad_half_nxt;
      row_base_r  <= row_base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      index_a_r <= index_a_nxt;
      index_b_r <= index_b_nxt;
      index_c_r <= index_c_nxt;
      last_r    <= last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_index_a       = index_a_r;
  assign out_index_b       = index_b_r;
  assign out_index_c       = index_c_r;
  assign out_last_triangle = last_r;

endmodule

`default_nettype wire
